// ===== design/luhn_pkg.sv =====
// ----------------------------------------------------------------------------
// luhn_pkg
// shared word types, verdict codes and digit arithmetic for the luhn checker
// ----------------------------------------------------------------------------
package luhn_pkg;

    // verdict codes
    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_BRAND_A = 2'd1;  // fifteen digits, prefix 34 or 37
    localparam logic [1:0] VERDICT_BRAND_B = 2'd2;  // sixteen digits, prefix 51..55
    localparam logic [1:0] VERDICT_BRAND_C = 2'd3;  // thirteen or sixteen digits, lead 4

    localparam logic [4:0] COUNT_MAX = 5'd31;

    // length and prefix rules
    localparam logic [4:0] LEN_BRAND_A   = 5'd15;
    localparam logic [4:0] LEN_BRAND_B   = 5'd16;
    localparam logic [4:0] LEN_BRAND_C_S = 5'd13;
    localparam logic [4:0] LEN_BRAND_C_L = 5'd16;
    localparam logic [7:0] PREFIX_A_LO   = 8'd34;
    localparam logic [7:0] PREFIX_A_HI   = 8'd37;
    localparam logic [7:0] PREFIX_B_MIN  = 8'd51;
    localparam logic [7:0] PREFIX_B_MAX  = 8'd55;
    localparam logic [3:0] LEAD_BRAND_C  = 4'd4;

    typedef struct packed {
        logic [3:0] digit;
        logic       last_digit;
    } in_word_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       checksum_ok;
        logic [4:0] digit_count;
    } out_word_t;

    // luhn doubling: 2d, or its digit sum 2d - 9 when 2d is ten or more
    function automatic logic [4:0] doubled_value(input logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        return (t >= 5'd10) ? (t - 5'd9) : t;
    endfunction

    // acc stays below ten, v below 22, so the sum stays below 31
    // and at most three tens come off
    function automatic logic [3:0] add_mod10(input logic [3:0] acc, input logic [4:0] v);
        logic [5:0] s;
        logic [5:0] r;
        s = {2'b00, acc} + {1'b0, v};
        if (s >= 6'd30)
            r = s - 6'd30;
        else if (s >= 6'd20)
            r = s - 6'd20;
        else if (s >= 6'd10)
            r = s - 6'd10;
        else
            r = s;
        return r[3:0];
    endfunction

endpackage

// ===== design/luhn_card_number_checker_core.sv =====
// ----------------------------------------------------------------------------
// luhn_card_number_checker_core
// the result word is registered and appears in the cycle after the last digit is accepted
// throughput: one digit word per cycle; the state update is a mod-10 add
//   and a few compares between the state registers and the result register
// a waiting result only blocks input when it is not taken in the same cycle
// reset clears both luhn sums, the digit count, the prefix and output valid
// ----------------------------------------------------------------------------
module luhn_card_number_checker_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  luhn_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output luhn_pkg::out_word_t  out_data
);

    // running state for the number in flight
    logic [3:0] sum_even_reg, sum_even_next;   // even positions doubled
    logic [3:0] sum_odd_reg,  sum_odd_next;    // odd positions doubled
    logic [4:0] count_reg,    count_next;      // saturating digit count
    logic [3:0] lead_reg,     lead_next;       // first digit
    logic [3:0] second_reg,   second_next;     // second digit

    // result register
    logic                out_valid_reg, out_valid_next;
    luhn_pkg::out_word_t out_data_reg,  out_data_next;

    logic       in_fire;
    logic [4:0] dbl;
    logic [3:0] chosen;
    logic       ok;
    logic [7:0] prefix;
    logic [1:0] verdict;
    logic [4:0] n;

    // a new word may enter whenever the result slot is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        dbl = luhn_pkg::doubled_value(in_data.digit);
        n   = (count_reg < luhn_pkg::COUNT_MAX) ? (count_reg + 5'd1) : luhn_pkg::COUNT_MAX;

        // prefix includes this word; first two digits come from the input
        lead_next   = (count_reg == 5'd0) ? in_data.digit : lead_reg;
        second_next = (count_reg == 5'd1) ? in_data.digit : second_reg;

        // position parity from the start picks which sum doubles this digit
        if (!count_reg[0])
        begin
            sum_even_next = luhn_pkg::add_mod10(sum_even_reg, dbl);
            sum_odd_next  = luhn_pkg::add_mod10(sum_odd_reg, {1'b0, in_data.digit});
        end
        else
        begin
            sum_odd_next  = luhn_pkg::add_mod10(sum_odd_reg, dbl);
            sum_even_next = luhn_pkg::add_mod10(sum_even_reg, {1'b0, in_data.digit});
        end

        // even length: even positions sit at odd distance from the end
        chosen = n[0] ? sum_odd_next : sum_even_next;
        ok     = (chosen == 4'd0);
        prefix = {lead_next, 3'b000} + {3'b000, lead_next, 1'b0} + {4'b0000, second_next};

        verdict = luhn_pkg::VERDICT_INVALID;
        if (ok)
        begin
            if (n == luhn_pkg::LEN_BRAND_A
                && (prefix == luhn_pkg::PREFIX_A_LO || prefix == luhn_pkg::PREFIX_A_HI))
                verdict = luhn_pkg::VERDICT_BRAND_A;
            else if (n == luhn_pkg::LEN_BRAND_B
                     && prefix >= luhn_pkg::PREFIX_B_MIN && prefix <= luhn_pkg::PREFIX_B_MAX)
                verdict = luhn_pkg::VERDICT_BRAND_B;
            else if ((n == luhn_pkg::LEN_BRAND_C_S || n == luhn_pkg::LEN_BRAND_C_L)
                     && lead_next == luhn_pkg::LEAD_BRAND_C)
                verdict = luhn_pkg::VERDICT_BRAND_C;
        end

        count_next = n;

        // last digit closes the number: clear every running value
        if (in_data.last_digit)
        begin
            sum_even_next = 4'd0;
            sum_odd_next  = 4'd0;
            count_next    = 5'd0;
            lead_next     = 4'd0;
            second_next   = 4'd0;
        end
    end

    // result slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (in_fire && in_data.last_digit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.verdict     = verdict;
            out_data_next.checksum_ok = ok;
            out_data_next.digit_count = n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_even_reg  <= 4'd0;
            sum_odd_reg   <= 4'd0;
            count_reg     <= 5'd0;
            lead_reg      <= 4'd0;
            second_reg    <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                sum_even_reg <= sum_even_next;
                sum_odd_reg  <= sum_odd_next;
                count_reg    <= count_next;
                lead_reg     <= lead_next;
                second_reg   <= second_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a result only appears after an accepted last digit
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire && in_data.last_digit))
        else $error("result appeared without a last digit");

    // running state is cleared once a number closes
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.last_digit) |=>
            (count_reg == 5'd0 && sum_even_reg == 4'd0 && sum_odd_reg == 4'd0
             && lead_reg == 4'd0 && second_reg == 4'd0))
        else $error("state not cleared after last digit");

    // sums stay proper residues modulo ten
    a_sums_mod10: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (sum_even_reg < 4'd10 && sum_odd_reg < 4'd10))
        else $error("luhn sum out of range");

    // every result has a nonzero length, and a brand verdict requires a passing checksum
    a_verdict_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.checksum_ok
                            || out_data_reg.verdict == luhn_pkg::VERDICT_INVALID)
                           && out_data_reg.digit_count != 5'd0))
        else $error("verdict without checksum or empty number");

endmodule
